[hw/rtl/sspq_pkg.sv]
// shared codes and types of the sorted priority queue
package sspq_pkg;

  // request codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one result word from the sequencer
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               empty;
    logic               full;
  } result_t;

endpackage

[hw/rtl/stable_sorted_priority_queue.sv]
// Stable sorted priority queue of DEPTH entries. Entries sit in one memory used as a ring,
// ordered from the front (highest priority) to the back; a new entry lands behind every
// stored entry of equal or higher priority, so ties leave in arrival order. One request
// word is taken at a time. A fetch reads the front entry, then moves the head pointer, then
// offers the result; an add reads from the back and moves each stored entry of lower priority
// back one slot, one memory read and write per entry, before it writes the new entry; an add to
// an empty or full queue or a fetch from an empty queue goes straight to the result state. The
// result enters the output register as the sequencer returns to idle. While the output
// register holds an untaken word, the sequencer waits. No clearing pass runs after reset.
module stable_sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] item_value,
  input  logic [7:0]         item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] fetched_value,
  output logic [1:0]         status,
  output logic               now_empty,
  output logic               now_full
);
  import sspq_pkg::*;

  logic    busy;
  logic    res_room;
  logic    res_push;
  result_t res;

  sspq_ctrl #(.DEPTH(DEPTH), .PRIORITY_BITS(PRIORITY_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (in_valid),
    .req_action   (action),
    .req_value    (item_value),
    .req_priority (item_priority),
    .busy         (busy),
    .res_room     (res_room),
    .res_push     (res_push),
    .res          (res)
  );

  // input side takes a word only while the sequencer is idle
  assign in_stall = busy;

  // output register has room when empty or being drained
  assign res_room = !out_valid || !out_stall;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (res_push) begin
      fetched_value <= res.value;
      status        <= res.status;
      now_empty     <= res.empty;
      now_full      <= res.full;
    end
  end

endmodule

[hw/rtl/sspq_mem.sv]
// entry store: one write port, one registered read port
module sspq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sspq_ctrl.sv]
// sequencer: ring of sorted entries in memory, insertion by shifting from the back
module sspq_ctrl #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_action,
  input  logic signed [31:0] req_value,
  input  logic [7:0]         req_priority,
  output logic               busy,
  input  logic               res_room,
  output logic               res_push,
  output sspq_pkg::result_t  res
);
  import sspq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PB = PRIORITY_BITS;
  localparam int MW = PB + 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state, state_next;
  logic [CW-1:0]      occ, occ_next;
  logic [IW-1:0]      head, head_next;
  logic [IW-1:0]      k, k_next;
  logic signed [31:0] new_val, new_val_next;
  logic [PB-1:0]      new_prio, new_prio_next;
  logic signed [31:0] res_value, res_value_next;
  logic [1:0]         res_status, res_status_next;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;
  logic [39:0]   prio_wide;
  logic [PB-1:0] prio_in;
  logic [PB-1:0] rd_prio;

  // physical slot of a position counted from the front
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  sspq_mem #(.DEPTH(DEPTH), .WIDTH(MW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // keep only the low priority bits
  assign prio_wide = {32'd0, req_priority};
  assign prio_in   = prio_wide[PB-1:0];
  assign rd_prio   = rdata[MW-1:32];

  assign busy     = (state != S_IDLE);
  assign res_push = (state == S_OUT) && res_room;

  // result word, flags from the updated count
  always_comb begin
    res.value  = res_value;
    res.status = res_status;
    res.empty  = (occ == '0);
    res.full   = (occ == CW'(DEPTH));
  end

  // sequencer
  always_comb begin
    state_next      = state;
    occ_next        = occ;
    head_next       = head;
    k_next          = k;
    new_val_next    = new_val;
    new_prio_next   = new_prio;
    res_value_next  = res_value;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = head;
    wdata           = {new_prio, new_val};
    raddr           = head;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          new_val_next    = req_value;
          new_prio_next   = prio_in;
          res_value_next  = '0;
          res_status_next = ST_OK;
          if (req_action == ACT_ADD) begin
            if (occ == CW'(DEPTH)) begin
              res_status_next = ST_FULL;
              state_next      = S_OUT;
            end else if (occ == '0) begin
              we         = 1'b1;
              waddr      = head;
              wdata      = {prio_in, req_value};
              occ_next   = CW'(1);
              state_next = S_OUT;
            end else begin
              k_next     = IW'(occ - CW'(1));
              raddr      = slot(head, IW'(occ - CW'(1)));
              state_next = S_SCAN;
            end
          end else begin
            if (occ == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              raddr      = head;
              state_next = S_FETCH;
            end
          end
        end
      end
      S_SCAN: begin
        // entry at position k is on the read port
        we    = 1'b1;
        waddr = slot(head, k + IW'(1));
        if (rd_prio < new_prio) begin
          wdata = rdata;
          if (k == '0) begin
            state_next = S_PLACE;
          end else begin
            k_next = k - IW'(1);
            raddr  = slot(head, k - IW'(1));
          end
        end else begin
          wdata      = {new_prio, new_val};
          occ_next   = occ + CW'(1);
          state_next = S_OUT;
        end
      end
      S_PLACE: begin
        // new entry goes to the front
        we         = 1'b1;
        waddr      = head;
        wdata      = {new_prio, new_val};
        occ_next   = occ + CW'(1);
        state_next = S_OUT;
      end
      S_FETCH: begin
        res_value_next = rdata[31:0];
        head_next      = slot(head, IW'(1));
        occ_next       = occ - CW'(1);
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (res_room) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      head  <= head_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k          <= k_next;
    new_val    <= new_val_next;
    new_prio   <= new_prio_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

endmodule

[tb/stable_sorted_priority_queue_tb.sv]
// testbench of the stable sorted priority queue: directed table, then random requests
`timescale 1ns / 1ps

module stable_sorted_priority_queue_tb;
  import sspq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PRIO_BITS    = 8;
  localparam logic [7:0] PRIO_MASK = 8'((1 << PRIO_BITS) - 1);
  localparam int N_ITEMS      = 1950;
  localparam int IDLE_PCT     = 18;
  localparam int QUIET_FIRST  = 700;
  localparam int QUIET_LAST   = 1000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 40;

  // one row of the directed table
  typedef struct {
    logic        act;
    logic [31:0] val;
    logic [7:0]  pri;
    bit          fixed;
    result_t     want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ACT_ADD;
  logic signed [31:0] item_value = '0;
  logic [7:0]         item_priority = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] fetched_value;
  logic [1:0]         status;
  logic               now_empty;
  logic               now_full;

  // queue contents as the predictor sees them, front at index 0
  logic [31:0] slot_val [QUEUE_DEPTH];
  logic [7:0]  slot_pri [QUEUE_DEPTH];
  int          held_count = 0;
  bit          filling = 1'b1;

  result_t     pending_results[$];
  stim_row_t   directed_rows[$];
  int          error_count = 0;
  bit          sender_done = 1'b0;

  stable_sorted_priority_queue #(
    .DEPTH(QUEUE_DEPTH),
    .PRIORITY_BITS(PRIO_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .item_value(item_value),
    .item_priority(item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fetched_value(fetched_value),
    .status(status),
    .now_empty(now_empty),
    .now_full(now_full)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // sorted insert behind equal or higher priorities, fetch from the front
  task automatic predict_request(input logic act, input logic [31:0] val,
                                 input logic [7:0] pri_in, output result_t r);
    int pos;
    int i;
    logic [7:0] pri;
    pri = pri_in & PRIO_MASK;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_ADD) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && slot_pri[pos] >= pri) pos++;
        for (i = held_count; i > pos; i--) begin
          slot_val[i] = slot_val[i - 1];
          slot_pri[i] = slot_pri[i - 1];
        end
        slot_val[pos] = val;
        slot_pri[pos] = pri;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = slot_val[0];
        for (i = 1; i < held_count; i++) begin
          slot_val[i - 1] = slot_val[i];
          slot_pri[i - 1] = slot_pri[i];
        end
        held_count--;
      end
    end
    r.empty = (held_count == 0);
    r.full  = (held_count >= QUEUE_DEPTH);
  endtask

  task automatic add_row(input logic act, input logic [31:0] val, input logic [7:0] pri,
                         input bit fixed, input result_t want);
    stim_row_t row;
    row.act   = act;
    row.val   = val;
    row.pri   = pri;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // swing between filling and draining so both full and empty are reached often
  task automatic make_random_request(output logic a, output logic [31:0] v,
                                     output logic [7:0] p);
    int roll;
    if (held_count >= QUEUE_DEPTH) filling = 1'b0;
    else if (held_count == 0) filling = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 10) a = 1'($urandom_range(0, 1));
    else if (roll < 85) a = filling ? ACT_ADD : ACT_FETCH;
    else a = filling ? ACT_FETCH : ACT_ADD;
    roll = $urandom_range(0, 99);
    if (roll < 45) p = 8'($urandom_range(0, 3));
    else if (roll < 55) p = roll[0] ? 8'hff : 8'h00;
    else p = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 5) v = 32'h8000_0000;
    else if (roll < 10) v = 32'h7fff_ffff;
    else v = $urandom;
  endtask

  // reset and end of run
  initial begin : run_control
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (!(sender_done && pending_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("stable_sorted_priority_queue_tb passed");
    end else begin
      $display("stable_sorted_priority_queue_tb failed");
    end
    $finish;
  end

  // request sender: directed table first, then random requests
  initial begin : sender
    stim_row_t row;
    result_t   r;
    int        taken;
    int        presented;
    logic        a;
    logic [31:0] v;
    logic [7:0]  p;
    bit          fixed_now;
    result_t     fixed_want;

    // empty queue, extremes, ties, fill to full and one add past full
    add_row(ACT_FETCH, 32'h0, 8'h00, 1'b1, {32'd0, ST_EMPTY, 1'b1, 1'b0});
    add_row(ACT_ADD, 32'h8000_0000, 8'h00, 1'b1, {32'd0, ST_OK, 1'b0, 1'b0});
    add_row(ACT_ADD, 32'h7fff_ffff, 8'hff, 1'b1, {32'd0, ST_OK, 1'b0, 1'b0});
    add_row(ACT_ADD, 32'h0000_0005, 8'h80, 1'b0, '0);
    add_row(ACT_ADD, 32'h0000_0006, 8'h80, 1'b0, '0);
    add_row(ACT_ADD, 32'hffff_ffff, 8'h80, 1'b0, '0);
    add_row(ACT_ADD, 32'h0000_0001, 8'h00, 1'b0, '0);
    add_row(ACT_FETCH, 32'hffff_ffff, 8'hff, 1'b0, '0);
    add_row(ACT_ADD, 32'h1111_1111, 8'h01, 1'b0, '0);
    add_row(ACT_ADD, 32'h2222_2222, 8'hfe, 1'b0, '0);
    add_row(ACT_ADD, 32'h3333_3333, 8'h55, 1'b0, '0);
    add_row(ACT_ADD, 32'h4444_4444, 8'haa, 1'b0, '0);
    add_row(ACT_ADD, 32'h5555_5555, 8'h80, 1'b0, '0);
    add_row(ACT_ADD, 32'h6666_6666, 8'h7f, 1'b0, '0);
    add_row(ACT_ADD, 32'h7777_7777, 8'h00, 1'b0, '0);
    add_row(ACT_ADD, 32'h8888_8888, 8'hff, 1'b0, '0);
    add_row(ACT_ADD, 32'h9999_9999, 8'h0f, 1'b0, '0);
    add_row(ACT_ADD, 32'haaaa_aaaa, 8'hf0, 1'b0, '0);
    add_row(ACT_ADD, 32'hbbbb_bbbb, 8'h80, 1'b0, '0);
    add_row(ACT_ADD, 32'hcccc_cccc, 8'hff, 1'b1, {32'd0, ST_FULL, 1'b0, 1'b1});
    add_row(ACT_FETCH, 32'h0, 8'h00, 1'b0, '0);
    add_row(ACT_ADD, 32'hdddd_dddd, 8'hff, 1'b0, '0);

    taken = 0;
    presented = 0;
    fixed_now = 1'b0;
    fixed_want = '0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (taken < N_ITEMS) begin
      @(posedge clk);
      // word accepted at this edge
      if (in_valid && !in_stall) begin
        predict_request(action, item_value, item_priority, r);
        pending_results.push_back(fixed_now ? fixed_want : r);
        taken++;
      end
      // offer the next word or idle
      if (!in_valid || !in_stall) begin
        if (presented < N_ITEMS &&
            ((presented >= QUIET_FIRST && presented < QUIET_LAST) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          if (presented < directed_rows.size()) begin
            row = directed_rows[presented];
            a = row.act;
            v = row.val;
            p = row.pri;
            fixed_now = row.fixed;
            fixed_want = row.want;
          end else begin
            make_random_request(a, v, p);
            fixed_now = 1'b0;
          end
          in_valid      <= 1'b1;
          action        <= a;
          item_value    <= v;
          item_priority <= p;
          presented++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    sender_done = 1'b1;
  end

  // result receiver with random stalls and one long hold-off
  initial begin : receiver
    result_t seen;
    result_t want;
    int      got_count;
    int      hold_left;
    bit      pressure_done;
    got_count = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        seen = {fetched_value, status, now_empty, now_full};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word value=%h status=%0d empty=%b full=%b",
                                    seen.value, seen.status, seen.empty, seen.full));
        end else begin
          want = pending_results.pop_front();
          if (seen.value !== want.value)
            report_mismatch($sformatf("word %0d fetched_value %h, want %h",
                                      got_count, seen.value, want.value));
          if (seen.status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      got_count, seen.status, want.status));
          if (seen.empty !== want.empty)
            report_mismatch($sformatf("word %0d now_empty %b, want %b",
                                      got_count, seen.empty, want.empty));
          if (seen.full !== want.full)
            report_mismatch($sformatf("word %0d now_full %b, want %b",
                                      got_count, seen.full, want.full));
        end
        got_count++;
      end
      // long hold-off so the block backs up into its input
      if (!pressure_done && got_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (got_count >= QUIET_FIRST && got_count < QUIET_LAST) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[%0t] timeout, %0d results outstanding", $realtime,
                 pending_results.size());
        $display("stable_sorted_priority_queue_tb failed");
        $finish;
      end
    end
  end

endmodule
